[src/iprms_pkg.sv]
// ----------------------------------------------------------------------------
// Patch RMS distance package
// Shared types, register map, command codes and defaults.
// ----------------------------------------------------------------------------
package iprms_pkg;

    // Payload and register widths
    localparam int DATA_W     = 16;
    localparam int CFG_W_W    = 11;
    localparam int CFG_CH_W   = 3;
    localparam int CFG_PS_W   = 5;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // Parameter defaults
    localparam int IMAGE_WORDS_DEF  = 65536;
    localparam int MAX_PATCH_DEF    = 16;
    localparam int MAX_CHANNELS_DEF = 4;

    // Register reset values and limits
    localparam int WIDTH_RST = 64;
    localparam int WIDTH_MAX = 1024;
    localparam int CH_RST    = 1;
    localparam int PS_RST    = 8;

    // Full-scale sample value used for normalization
    localparam int FULL_SCALE = 255;

    // Register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
    localparam logic [1:0] REG_PATCH_SIZE    = 2'd2;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STRIDE,
        S_SPAN,
        S_CHECK,
        S_WALK,
        S_DRAIN,
        S_ROOT
    } t_state;

    typedef enum logic [2:0] {
        U_IDLE,
        U_DIV,
        U_SQRT,
        U_SCALE,
        U_FIN
    } t_root_state;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } t_root_status;

endpackage

[src/iprms_root.sv]
// ----------------------------------------------------------------------------
// Patch RMS distance root unit
// Divides the squared-difference sum by the element count, takes the integer
// square root and scales by 256/255, with one shared subtractor.
// ----------------------------------------------------------------------------
module iprms_root #(
    parameter int SSD_W = 43,
    parameter int N_W   = 11
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [SSD_W-1:0]          i_ssd,
    input  logic [N_W-1:0]            i_count,
    output iprms_pkg::t_root_status   o_status
);
    import iprms_pkg::*;

    localparam int CNT_W = $clog2(SSD_W);

    t_root_state r_state, n_state;
    logic [SSD_W-1:0] r_quo, n_quo;
    logic [N_W-1:0]   r_rem, n_rem;
    logic [N_W-1:0]   r_div, n_div;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]      r_val, n_val;
    logic [31:0]      r_res, n_res;
    logic [31:0]      r_bit, n_bit;
    logic [8:0]       r_q, n_q;
    logic             r_done, n_done;
    logic [DATA_W-1:0] r_result, n_result;

    logic [N_W:0]  rem_sh;
    logic [32:0]   sub_a, sub_b, sub_d;
    logic          sub_ge;

    // Shared subtract and compare
    always_comb begin
        rem_sh = {r_rem, r_quo[SSD_W-1]};
        sub_a  = '0;
        sub_b  = '0;
        case (r_state)
            U_DIV: begin
                sub_a = 33'(rem_sh);
                sub_b = 33'(r_div);
            end
            U_SQRT: begin
                sub_a = {1'b0, r_val};
                sub_b = {1'b0, r_res + r_bit};
            end
            default: begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
        sub_d  = sub_a - sub_b;
        sub_ge = ~sub_d[32];
    end

    always_comb begin
        logic [15:0] root;
        logic [24:0] prod;
        logic [16:0] rem_s;
        logic [8:0]  q_fix;
        logic [16:0] total;
        n_state  = r_state;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_div    = r_div;
        n_cnt    = r_cnt;
        n_val    = r_val;
        n_res    = r_res;
        n_bit    = r_bit;
        n_q      = r_q;
        n_done   = 1'b0;
        n_result = r_result;
        root     = r_res[15:0];
        prod     = {1'b0, root, 8'h00} + 25'(root);
        rem_s    = 17'(root) - {r_q, 8'h00} + 17'(r_q);
        q_fix    = (rem_s >= 17'(FULL_SCALE)) ? r_q + 9'd1 : r_q;
        total    = 17'(root) + 17'(q_fix);
        case (r_state)
            U_IDLE: begin
                if (i_start) begin
                    n_quo   = i_ssd;
                    n_div   = i_count;
                    n_rem   = '0;
                    n_cnt   = CNT_W'(SSD_W - 1);
                    n_state = U_DIV;
                end
            end
            U_DIV: begin
                if (sub_ge) begin
                    n_rem = sub_d[N_W-1:0];
                    n_quo = {r_quo[SSD_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[N_W-1:0];
                    n_quo = {r_quo[SSD_W-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    // Quotient is at most a squared sample difference
                    n_val   = n_quo[31:0];
                    n_res   = '0;
                    n_bit   = 32'h4000_0000;
                    n_state = U_SQRT;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            U_SQRT: begin
                if (sub_ge) begin
                    n_val = sub_d[31:0];
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_state = U_SCALE;
                end
            end
            U_SCALE: begin
                // Estimate root/255 from below as root*257 >> 16
                n_q     = prod[24:16];
                n_state = U_FIN;
            end
            U_FIN: begin
                n_result = total[16] ? {DATA_W{1'b1}} : total[15:0];
                n_done   = 1'b1;
                n_state  = U_IDLE;
            end
            default: begin
                n_state = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_div    <= n_div;
        r_cnt    <= n_cnt;
        r_val    <= n_val;
        r_res    <= n_res;
        r_bit    <= n_bit;
        r_q      <= n_q;
        r_result <= n_result;
    end

    assign o_status.done   = r_done;
    assign o_status.result = r_result;

endmodule

[src/image_patch_rms_distance.sv]
// ----------------------------------------------------------------------------
// Image patch RMS distance
// Stores an interleaved multichannel image and answers patch-to-patch
// RMS difference queries, normalized to full scale, in Q8.8.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  request   i_start / o_busy       i_cmd, i_element_index, i_element_value,
//                                   i_first_patch, i_second_patch
//  result    o_valid (strobe)       o_patch_distance, o_range_error
//  config    psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
//  A write request leaves o_busy low.
//  A query walks N = patch_size^2 * channel_count element pairs: the walk
//  reads one element pair a cycle through the two store read ports, then
//  the root unit finds one quotient bit a cycle and then the root bit by bit.
//  A query whose patch leaves the store answers from the check state, after the stride and span states.
//  Reset clears control state only; the store is undefined until written.
//  The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module image_patch_rms_distance #(
    parameter int IMAGE_WORDS  = iprms_pkg::IMAGE_WORDS_DEF,
    parameter int MAX_PATCH    = iprms_pkg::MAX_PATCH_DEF,
    parameter int MAX_CHANNELS = iprms_pkg::MAX_CHANNELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic                                i_cmd,
    input  logic [iprms_pkg::DATA_W-1:0]        i_element_index,
    input  logic [iprms_pkg::DATA_W-1:0]        i_element_value,
    input  logic [iprms_pkg::DATA_W-1:0]        i_first_patch,
    input  logic [iprms_pkg::DATA_W-1:0]        i_second_patch,
    output logic                                o_valid,
    output logic [iprms_pkg::DATA_W-1:0]        o_patch_distance,
    output logic                                o_range_error,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [iprms_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [iprms_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [iprms_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import iprms_pkg::*;

    // Reachable limits: register fields cap channels at 7 and size at 31
    localparam int C_MAX      = (MAX_CHANNELS > 7) ? 7 : MAX_CHANNELS;
    localparam int S_MAX      = (MAX_PATCH > 31) ? 31 : MAX_PATCH;
    localparam int AW         = $clog2(IMAGE_WORDS);
    localparam int STRIDE_MAX = WIDTH_MAX * C_MAX;
    localparam int SPAN_MAX   = (S_MAX - 1) * STRIDE_MAX + (S_MAX - 1) * C_MAX + C_MAX - 1;
    localparam int K_MAX      = S_MAX * S_MAX * C_MAX;
    localparam int STRIDE_W   = $clog2(STRIDE_MAX + 1);
    localparam int SPAN_W     = $clog2(SPAN_MAX + 1);
    localparam int NSQ_W      = $clog2(S_MAX * S_MAX + 1);
    localparam int N_W        = $clog2(K_MAX + 1);
    localparam int SSD_W      = 32 + N_W;
    localparam int SUM_RAW_W  = $clog2(65535 + SPAN_MAX + 1);
    localparam int SUM_W      = ((SUM_RAW_W > AW) ? SUM_RAW_W : AW) + 1;
    localparam int PS_RST_C   = (MAX_PATCH < PS_RST) ? MAX_PATCH : PS_RST;

    // Configuration registers
    logic [CFG_W_W-1:0]  r_width;
    logic [CFG_CH_W-1:0] r_ch;
    logic [CFG_PS_W-1:0] r_ps;
    logic                cfg_wr;
    logic [1:0]          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[3:2];

    // Clamp written values into their legal ranges
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= CFG_W_W'(WIDTH_RST);
            r_ch    <= CFG_CH_W'(CH_RST);
            r_ps    <= CFG_PS_W'(PS_RST_C);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_IMAGE_WIDTH: begin
                    if (pwdata[CFG_W_W-1:0] == '0) begin
                        r_width <= CFG_W_W'(1);
                    end else if (pwdata[CFG_W_W-1:0] > CFG_W_W'(WIDTH_MAX)) begin
                        r_width <= CFG_W_W'(WIDTH_MAX);
                    end else begin
                        r_width <= pwdata[CFG_W_W-1:0];
                    end
                end
                REG_CHANNEL_COUNT: begin
                    if (pwdata[CFG_CH_W-1:0] == '0) begin
                        r_ch <= CFG_CH_W'(1);
                    end else if (32'(pwdata[CFG_CH_W-1:0]) > 32'(MAX_CHANNELS)) begin
                        r_ch <= CFG_CH_W'(MAX_CHANNELS);
                    end else begin
                        r_ch <= pwdata[CFG_CH_W-1:0];
                    end
                end
                REG_PATCH_SIZE: begin
                    if (pwdata[CFG_PS_W-1:0] == '0) begin
                        r_ps <= CFG_PS_W'(1);
                    end else if (32'(pwdata[CFG_PS_W-1:0]) > 32'(MAX_PATCH)) begin
                        r_ps <= CFG_PS_W'(MAX_PATCH);
                    end else begin
                        r_ps <= pwdata[CFG_PS_W-1:0];
                    end
                end
                default: begin
                    // Unmapped register: drop the write
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_IMAGE_WIDTH:   prdata = APB_DATA_W'(r_width);
            REG_CHANNEL_COUNT: prdata = APB_DATA_W'(r_ch);
            REG_PATCH_SIZE:    prdata = APB_DATA_W'(r_ps);
            default:           prdata = '0;
        endcase
    end

    // Sequencer state
    t_state r_state, n_state;
    logic [DATA_W-1:0]   r_p1, n_p1;
    logic [DATA_W-1:0]   r_p2, n_p2;
    logic [STRIDE_W-1:0] r_stride, n_stride;
    logic [NSQ_W-1:0]    r_nsq, n_nsq;
    logic [SPAN_W-1:0]   r_span, n_span;
    logic [N_W-1:0]      r_n, n_n;
    logic [CFG_PS_W-1:0] r_hy, n_hy;
    logic [CFG_PS_W-1:0] r_hx, n_hx;
    logic [CFG_CH_W-1:0] r_hc, n_hc;
    logic [SPAN_W-1:0]   r_off, n_off;
    logic [SPAN_W-1:0]   r_row, n_row;
    logic                r_valid, n_valid;
    logic [DATA_W-1:0]   r_dist, n_dist;
    logic                r_err, n_err;
    logic                root_start;

    logic                accept;
    logic                walk;
    logic [SUM_W-1:0]    end1, end2, addr1, addr2;

    // Element-pair pipeline
    logic [DATA_W-1:0]   r_a, r_b;
    logic                r_ab_v;
    logic [31:0]         r_sq;
    logic                r_sq_v;
    logic [SSD_W-1:0]    r_ssd;
    logic [DATA_W-1:0]   diff;

    t_root_status        root_st;

    logic [DATA_W-1:0]   r_mem [IMAGE_WORDS];

    assign accept = i_start & ~o_busy;
    assign o_busy = (r_state != S_IDLE);
    assign walk   = (r_state == S_WALK);
    assign end1   = SUM_W'(r_p1) + SUM_W'(r_span);
    assign end2   = SUM_W'(r_p2) + SUM_W'(r_span);
    assign addr1  = SUM_W'(r_p1) + SUM_W'(r_off);
    assign addr2  = SUM_W'(r_p2) + SUM_W'(r_off);

    always_comb begin
        n_state    = r_state;
        n_p1       = r_p1;
        n_p2       = r_p2;
        n_stride   = r_stride;
        n_nsq      = r_nsq;
        n_span     = r_span;
        n_n        = r_n;
        n_hy       = r_hy;
        n_hx       = r_hx;
        n_hc       = r_hc;
        n_off      = r_off;
        n_row      = r_row;
        n_valid    = 1'b0;
        n_dist     = r_dist;
        n_err      = r_err;
        root_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_cmd == CMD_QUERY)) begin
                    n_p1    = i_first_patch;
                    n_p2    = i_second_patch;
                    n_state = S_STRIDE;
                end
            end
            S_STRIDE: begin
                n_stride = STRIDE_W'(STRIDE_W'(r_ch) * STRIDE_W'(r_width));
                n_nsq    = NSQ_W'(NSQ_W'(r_ps) * NSQ_W'(r_ps));
                n_state  = S_SPAN;
            end
            S_SPAN: begin
                // Offset of the last element of a patch
                n_span  = SPAN_W'(SPAN_W'(r_ps - CFG_PS_W'(1)) * SPAN_W'(r_stride))
                        + SPAN_W'(SPAN_W'(r_ps - CFG_PS_W'(1)) * SPAN_W'(r_ch))
                        + SPAN_W'(r_ch - CFG_CH_W'(1));
                n_n     = N_W'(N_W'(r_nsq) * N_W'(r_ch));
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if ((end1 >= SUM_W'(IMAGE_WORDS)) || (end2 >= SUM_W'(IMAGE_WORDS))) begin
                    // Patch leaves the store: answer at once
                    n_valid = 1'b1;
                    n_dist  = '0;
                    n_err   = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_hy    = '0;
                    n_hx    = '0;
                    n_hc    = '0;
                    n_off   = '0;
                    n_row   = '0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (r_hc == r_ch - CFG_CH_W'(1)) begin
                    n_hc = '0;
                    if (r_hx == r_ps - CFG_PS_W'(1)) begin
                        // Row end: advance to the next image row
                        n_hx  = '0;
                        n_row = r_row + SPAN_W'(r_stride);
                        n_off = r_row + SPAN_W'(r_stride);
                        if (r_hy == r_ps - CFG_PS_W'(1)) begin
                            n_state = S_DRAIN;
                        end else begin
                            n_hy = r_hy + CFG_PS_W'(1);
                        end
                    end else begin
                        n_hx  = r_hx + CFG_PS_W'(1);
                        n_off = r_off + SPAN_W'(1);
                    end
                end else begin
                    n_hc  = r_hc + CFG_CH_W'(1);
                    n_off = r_off + SPAN_W'(1);
                end
            end
            S_DRAIN: begin
                // Wait until the last pair has reached the sum
                if (!r_ab_v && !r_sq_v) begin
                    root_start = 1'b1;
                    n_state    = S_ROOT;
                end
            end
            S_ROOT: begin
                if (root_st.done) begin
                    n_valid = 1'b1;
                    n_dist  = root_st.result;
                    n_err   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_ab_v  <= 1'b0;
            r_sq_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_ab_v  <= walk;
            r_sq_v  <= r_ab_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1     <= n_p1;
        r_p2     <= n_p2;
        r_stride <= n_stride;
        r_nsq    <= n_nsq;
        r_span   <= n_span;
        r_n      <= n_n;
        r_hy     <= n_hy;
        r_hx     <= n_hx;
        r_hc     <= n_hc;
        r_off    <= n_off;
        r_row    <= n_row;
        r_dist   <= n_dist;
        r_err    <= n_err;
    end

    // Image store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (accept && (i_cmd == CMD_WRITE)
            && (32'(i_element_index) < 32'(IMAGE_WORDS))) begin
            r_mem[AW'(i_element_index)] <= i_element_value;
        end
        r_a <= r_mem[addr1[AW-1:0]];
        r_b <= r_mem[addr2[AW-1:0]];
    end

    // Square the difference, then accumulate
    assign diff = (r_a >= r_b) ? (r_a - r_b) : (r_b - r_a);

    always_ff @(posedge i_clk) begin
        r_sq <= 32'(diff) * 32'(diff);
        if (r_state == S_CHECK) begin
            r_ssd <= '0;
        end else if (r_sq_v) begin
            r_ssd <= r_ssd + SSD_W'(r_sq);
        end
    end

    iprms_root #(
        .SSD_W (SSD_W),
        .N_W   (N_W)
    ) u_root (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (root_start),
        .i_ssd    (r_ssd),
        .i_count  (r_n),
        .o_status (root_st)
    );

    assign o_valid          = r_valid;
    assign o_patch_distance = r_dist;
    assign o_range_error    = r_err;

endmodule
